### sv/pidwin_pkg.sv
// pidwin_pkg: shared widths, register indexes and a helper for the windowed pid controller
// depends on nothing; imported by pid_controller_windowed_integral
`default_nettype none

package pidwin_pkg;

  localparam int GAIN_W    = 16;
  localparam int DT_W      = 16;
  localparam int DRIVE_W   = 32;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GAIN_P = 2'd0;
  localparam cfg_idx_t CFG_GAIN_I = 2'd1;
  localparam cfg_idx_t CFG_GAIN_D = 2'd2;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 32'h7fff_ffff;
  localparam logic [DRIVE_W-1:0] DRIVE_MIN = 32'h8000_0000;

  // magnitude of a signed q8.8 gain, the most negative code maps to 2^15
  function automatic logic [GAIN_W-1:0] gain_mag(input logic [GAIN_W-1:0] g);
    logic [GAIN_W-1:0] res;
    res = g[GAIN_W-1] ? (~g + 1'b1) : g;
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/pid_controller_windowed_integral.sv
// pid_controller_windowed_integral: pid drive with an integral over a sliding window
// depends on pidwin_pkg (widths, register indexes, gain magnitude helper)
// How to use this block:
//   input channel: in_valid / in_stall with setpoint, measurement and elapsed_ms; the
//   word is taken on a rising edge with in_valid high and in_stall low. in_stall is high
//   while a word is being worked on, one word at a time.
//   result channel: out_valid / out_stall with drive and saturated; the result sits in
//   an output register, so a new input word is taken while it still waits.
//   cfg port: gain_p, gain_i, gain_d written at indexes 0..2 when cfg_we is high;
//   index 3 is ignored. Write gains only while the block is idle.
// Datapath: one shared bit-serial shift-add multiplier and one restoring divider, one
//   bit per cycle. An empty time window skips the integral, elapsed_ms of zero skips
//   the derivative. The integral division over the 51-bit dividend dominates.
// Reset (synchronous, rst_n low) clears the gains, the window, the previous error and
//   the output valid. If the receiver stalls, the finished word waits in the output
//   register; a following word is held after its last step until the register frees.
`default_nettype none

module pid_controller_windowed_integral #(
  parameter int WINDOW_LEN     = 5,
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [SAMPLE_BITS-1:0]         in_setpoint,
  input  wire  signed [SAMPLE_BITS-1:0]         in_measurement,
  input  wire         [pidwin_pkg::DT_W-1:0]    in_elapsed_ms,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [pidwin_pkg::DRIVE_W-1:0] out_drive,
  output logic                                  out_saturated,
  input  wire                                   cfg_we,
  input  wire  pidwin_pkg::cfg_idx_t            cfg_index,
  input  wire         [pidwin_pkg::GAIN_W-1:0]  cfg_data
);

  import pidwin_pkg::*;

  localparam int EW     = SAMPLE_BITS + 1;
  localparam int EMW    = SAMPLE_BITS;
  localparam int DMW    = SAMPLE_BITS + 1;
  localparam int DEW    = SAMPLE_BITS + 2;
  localparam int WLOG   = $clog2(WINDOW_LEN);
  localparam int SMW    = SAMPLE_BITS + WLOG;
  localparam int SEW    = SMW + 1;
  localparam int STW    = DT_W + WLOG;
  localparam int PLW    = GAIN_W + EMW;
  localparam int L1     = GAIN_W + SMW;
  localparam int L2     = L1 + DT_W;
  localparam int LD     = GAIN_W + DMW;
  localparam int PW     = L2;
  localparam int TW_MIN = L2 + 3;
  localparam int TW_SAT = DRIVE_W + GAIN_FRAC_BITS + 1;
  localparam int TW     = (TW_MIN > TW_SAT) ? TW_MIN : TW_SAT;
  localparam int CW     = $clog2(PW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_P_MUL, S_I_MUL1, S_I_MUL2, S_I_DIV, S_D_MUL, S_D_DIV, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0] out_drive_r, out_drive_nxt;
  logic                     out_sat_r, out_sat_nxt;
  logic [GAIN_W-1:0]        gain_p_r, gain_p_nxt;
  logic [GAIN_W-1:0]        gain_i_r, gain_i_nxt;
  logic [GAIN_W-1:0]        gain_d_r, gain_d_nxt;
  logic signed [EW-1:0]     prev_r, prev_nxt;
  logic signed [SEW-1:0]    sum_err_r, sum_err_nxt;
  logic [STW-1:0]           sum_time_r, sum_time_nxt;
  logic signed [EW-1:0]     win_err_r [WINDOW_LEN];
  logic signed [EW-1:0]     win_err_nxt [WINDOW_LEN];
  logic [DT_W-1:0]          win_time_r [WINDOW_LEN];
  logic [DT_W-1:0]          win_time_nxt [WINDOW_LEN];

  // datapath words, no reset needed
  logic [PW-1:0]            acc_r, acc_nxt;
  logic [GAIN_W-1:0]        mc_r, mc_nxt;
  logic [STW-1:0]           dv_r, dv_nxt;
  logic [STW-1:0]           rem_r, rem_nxt;
  logic signed [TW-1:0]     tot_r, tot_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [EW-1:0]     err_r, err_nxt;
  logic [DT_W-1:0]          dt_r, dt_nxt;

  logic [GAIN_W-1:0]        mc_sel;
  logic [GAIN_W:0]          mul_sum;
  logic [PW-1:0]            mul_acc;
  logic [STW:0]             rem_sh;
  logic [STW+1:0]           sub_full;
  logic                     q_bit;
  logic [STW-1:0]           div_rem;
  logic [PW-1:0]            div_acc;
  logic [TW-1:0]            term_mag;
  logic [TW-1:0]            tot_sum;
  logic [EMW-1:0]           err_abs;
  logic [SMW-1:0]           sum_abs;
  logic [DEW-1:0]           derr;
  logic [DMW-1:0]           derr_abs;
  logic signed [TW-1:0]     shifted;
  logic                     fits;
  logic                     start_i;
  logic                     start_d;

  // shift-add multiplier step: add multiplicand into the top, shift right one bit
  assign mc_sel  = acc_r[0] ? mc_r : '0;
  assign mul_sum = {1'b0, acc_r[PW-1 -: GAIN_W]} + {1'b0, mc_sel};
  assign mul_acc = {mul_sum, acc_r[PW-GAIN_W-1:1]};

  // restoring divider step: dividend msb first, quotient bits enter at the bottom
  assign rem_sh   = {rem_r, acc_r[PW-1]};
  assign sub_full = {1'b0, rem_sh} - {2'b00, dv_r};
  assign q_bit    = ~sub_full[STW+1];
  assign div_rem  = q_bit ? sub_full[STW-1:0] : rem_sh[STW-1:0];
  assign div_acc  = {acc_r[PW-2:0], q_bit};

  always_comb begin
    unique case (state_r)
      S_P_MUL: term_mag = TW'(acc_r[PW-1 -: PLW]);
      S_I_DIV: term_mag = TW'(acc_r[L2-1:0]);
      default: term_mag = TW'(acc_r[LD-1:0]);
    endcase
  end

  assign tot_sum = neg_r ? (tot_r - term_mag) : (tot_r + term_mag);

  assign err_abs  = err_r[EW-1] ? EMW'(-err_r) : EMW'(err_r);
  assign sum_abs  = sum_err_r[SEW-1] ? SMW'(-sum_err_r) : SMW'(sum_err_r);
  assign derr     = {err_r[EW-1], err_r} - {prev_r[EW-1], prev_r};
  assign derr_abs = derr[DEW-1] ? DMW'(-derr) : DMW'(derr);

  // floor shift out of q8.8, then clip to the 32-bit range
  assign shifted = tot_r >>> GAIN_FRAC_BITS;
  assign fits    = (&shifted[TW-1:DRIVE_W-1]) | ~(|shifted[TW-1:DRIVE_W-1]);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_drive_nxt = out_drive_r;
    out_sat_nxt   = out_sat_r;
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    prev_nxt      = prev_r;
    sum_err_nxt   = sum_err_r;
    sum_time_nxt  = sum_time_r;
    win_err_nxt   = win_err_r;
    win_time_nxt  = win_time_r;
    acc_nxt       = acc_r;
    mc_nxt        = mc_r;
    dv_nxt        = dv_r;
    rem_nxt       = rem_r;
    tot_nxt       = tot_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    err_nxt       = err_r;
    dt_nxt        = dt_r;
    start_i       = 1'b0;
    start_d       = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P: gain_p_nxt = cfg_data;
        CFG_GAIN_I: gain_i_nxt = cfg_data;
        CFG_GAIN_D: gain_d_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt   = {in_measurement[SAMPLE_BITS-1], in_measurement}
                    - {in_setpoint[SAMPLE_BITS-1], in_setpoint};
          dt_nxt    = in_elapsed_ms;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        acc_nxt   = PW'(err_abs);
        mc_nxt    = gain_mag(gain_p_r);
        neg_nxt   = gain_p_r[GAIN_W-1] ^ err_r[EW-1];
        cnt_nxt   = CW'(EMW);
        tot_nxt   = '0;
        state_nxt = S_P_MUL;
      end
      S_P_MUL: begin
        if (cnt_r != '0) begin
          acc_nxt = mul_acc;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          tot_nxt = tot_sum;
          if (sum_time_r != '0) begin
            start_i = 1'b1;
          end else begin
            start_d = 1'b1;
          end
        end
      end
      S_I_MUL1: begin
        if (cnt_r != '0) begin
          acc_nxt = mul_acc;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          // gain times error sum becomes the multiplier against elapsed time
          acc_nxt   = PW'(acc_r[PW-1 -: L1]);
          mc_nxt    = GAIN_W'(dt_r);
          cnt_nxt   = CW'(L1);
          state_nxt = S_I_MUL2;
        end
      end
      S_I_MUL2: begin
        if (cnt_r != '0) begin
          acc_nxt = mul_acc;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          rem_nxt   = '0;
          dv_nxt    = sum_time_r;
          cnt_nxt   = CW'(L2);
          state_nxt = S_I_DIV;
        end
      end
      S_I_DIV: begin
        if (cnt_r != '0) begin
          acc_nxt = div_acc;
          rem_nxt = div_rem;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          tot_nxt = tot_sum;
          start_d = 1'b1;
        end
      end
      S_D_MUL: begin
        if (cnt_r != '0) begin
          acc_nxt = mul_acc;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          rem_nxt   = '0;
          dv_nxt    = STW'(dt_r);
          cnt_nxt   = CW'(LD);
          state_nxt = S_D_DIV;
        end
      end
      S_D_DIV: begin
        if (cnt_r != '0) begin
          acc_nxt = div_acc;
          rem_nxt = div_rem;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          tot_nxt   = tot_sum;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sat_nxt   = ~fits;
          if (fits) begin
            out_drive_nxt = shifted[DRIVE_W-1:0];
          end else if (shifted[TW-1]) begin
            out_drive_nxt = DRIVE_MIN;
          end else begin
            out_drive_nxt = DRIVE_MAX;
          end
          // window shifts toward the oldest tap, unfilled taps are still zero
          prev_nxt     = err_r;
          sum_err_nxt  = sum_err_r + SEW'(err_r) - SEW'(win_err_r[WINDOW_LEN-1]);
          sum_time_nxt = sum_time_r + STW'(dt_r) - STW'(win_time_r[WINDOW_LEN-1]);
          win_err_nxt[0]  = err_r;
          win_time_nxt[0] = dt_r;
          for (int k = 1; k < WINDOW_LEN; k++) begin
            win_err_nxt[k]  = win_err_r[k-1];
            win_time_nxt[k] = win_time_r[k-1];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (start_i) begin
      acc_nxt   = PW'(sum_abs);
      mc_nxt    = gain_mag(gain_i_r);
      neg_nxt   = gain_i_r[GAIN_W-1] ^ sum_err_r[SEW-1];
      cnt_nxt   = CW'(SMW);
      state_nxt = S_I_MUL1;
    end

    if (start_d) begin
      if (dt_r != '0) begin
        acc_nxt   = PW'(derr_abs);
        mc_nxt    = gain_mag(gain_d_r);
        neg_nxt   = gain_d_r[GAIN_W-1] ^ derr[DEW-1];
        cnt_nxt   = CW'(DMW);
        state_nxt = S_D_MUL;
      end else begin
        state_nxt = S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_drive_r <= '0;
      out_sat_r   <= 1'b0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      prev_r      <= '0;
      sum_err_r   <= '0;
      sum_time_r  <= '0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        win_err_r[k]  <= '0;
        win_time_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_drive_r <= out_drive_nxt;
      out_sat_r   <= out_sat_nxt;
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      prev_r      <= prev_nxt;
      sum_err_r   <= sum_err_nxt;
      sum_time_r  <= sum_time_nxt;
      win_err_r   <= win_err_nxt;
      win_time_r  <= win_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    dv_r  <= dv_nxt;
    rem_r <= rem_nxt;
    tot_r <= tot_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    err_r <= err_nxt;
    dt_r  <= dt_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_saturated = out_sat_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after taking a word");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN))
    else $error("result raised outside the final step");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_I_DIV || state_r == S_D_DIV) |-> (rem_r < dv_r))
    else $error("divider remainder not below divisor");

  a_no_zero_dt_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_MUL || state_r == S_D_DIV) |-> (dt_r != '0))
    else $error("derivative term started with zero elapsed time");

  a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_drive == DRIVE_MAX || out_drive == DRIVE_MIN))
    else $error("saturated flag without a clipped drive");
`endif

endmodule

`default_nettype wire
